// ===== sv/integer_set_engine_assert.svh =====
// Assertion macros used by the integer set engine datapath.
`ifndef INTEGER_SET_ENGINE_ASSERT_SVH
`define INTEGER_SET_ENGINE_ASSERT_SVH

`ifndef SYNTH
`define ISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_set_engine: same-cycle check failed");
`define ISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_set_engine: next-cycle check failed");
`else
`define ISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ise_pkg.sv =====
// Types and constants of the integer set engine.
package ise_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] OP_INS_A = 3'd0;
  localparam logic [2:0] OP_INS_B = 3'd1;
  localparam logic [2:0] OP_QRY_A = 3'd2;
  localparam logic [2:0] OP_QRY_B = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_UNION = 3'd5;
  localparam logic [2:0] OP_INTER = 3'd6;
  localparam logic [2:0] OP_DIFF  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } set_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     found;
    logic [1:0]               status;
    logic                     last;
  } set_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic exec;      // run insert / query / clear and load the result
    logic idx_clr;   // restart the scan index
    logic mode_a;    // scanning A against B
    logic mode_b;    // scanning B against A
    logic step;      // advance the scan by one entry
    logic finish;    // emit the final item of a set operation
  } ise_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic set_op;
    logic is_union;
    logic a_end;
    logic b_end;
    logic stall;
    logic out_free;
  } ise_sts_t;

endpackage

// ===== sv/ise_dp.sv =====
// Datapath: set storage, parallel match, scan index, pending item and output register.
module ise_dp import ise_pkg::*; #(
  parameter int SET_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  set_in_t  in_data,
  input  ise_cmd_t cmd,
  output ise_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output set_out_t out_data
);

`include "integer_set_engine_assert.svh"

  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  logic [2:0]               op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [DATA_W-1:0]        a_r [SET_DEPTH];
  logic [DATA_W-1:0]        b_r [SET_DEPTH];
  logic [CNT_W-1:0]         cnt_a_r, cnt_b_r, idx_r;
  logic [DATA_W-1:0]        pend_r;
  logic                     pend_v_r;
  set_out_t                 out_r, out_nxt;
  logic                     out_v_r, out_v_nxt;
  logic                     out_load;

  logic [DATA_W-1:0] a_rd, b_rd, probe_a, probe_b, scan_item;
  logic              hit_a, hit_b, full_a, full_b;
  logic              take, take_a;
  logic              is_ins, is_qry, sel_a, hit, full;
  logic              out_free;

  assign a_rd    = a_r[idx_r[AW-1:0]];
  assign b_rd    = b_r[idx_r[AW-1:0]];
  assign probe_a = cmd.mode_b ? b_rd : val_r;
  assign probe_b = cmd.mode_a ? a_rd : val_r;

  // compare the probe against every live entry at once
  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      hit_a = hit_a | ((CNT_W'(i) < cnt_a_r) && (a_r[i] == probe_a));
      hit_b = hit_b | ((CNT_W'(i) < cnt_b_r) && (b_r[i] == probe_b));
    end
  end

  assign full_a = (cnt_a_r == CNT_W'(SET_DEPTH));
  assign full_b = (cnt_b_r == CNT_W'(SET_DEPTH));

  assign take_a = (op_r == OP_UNION) || ((op_r == OP_INTER) && hit_b) ||
                  ((op_r == OP_DIFF) && !hit_b);
  assign take      = cmd.mode_a ? take_a : !hit_a;
  assign scan_item = cmd.mode_a ? a_rd : b_rd;

  assign is_ins = (op_r == OP_INS_A) || (op_r == OP_INS_B);
  assign is_qry = (op_r == OP_QRY_A) || (op_r == OP_QRY_B);
  assign sel_a  = (op_r == OP_INS_A) || (op_r == OP_QRY_A);
  assign hit    = sel_a ? hit_a : hit_b;
  assign full   = sel_a ? full_a : full_b;

  assign out_free = !out_v_r || out_ready;

  assign sts.set_op   = (op_r == OP_UNION) || (op_r == OP_INTER) || (op_r == OP_DIFF);
  assign sts.is_union = (op_r == OP_UNION);
  assign sts.a_end    = (idx_r >= cnt_a_r);
  assign sts.b_end    = (idx_r >= cnt_b_r);
  assign sts.stall    = take && pend_v_r && !out_free;
  assign sts.out_free = out_free;

  // one element is held back so the final one can carry last
  always_comb begin
    out_nxt  = out_r;
    out_load = 1'b0;
    if (cmd.exec) begin
      out_load              = 1'b1;
      out_nxt.element       = val_r;
      out_nxt.element_valid = 1'b0;
      out_nxt.found         = is_qry && hit;
      out_nxt.status        = !is_ins ? ST_OK : (hit ? ST_DUP : (full ? ST_FULL : ST_OK));
      out_nxt.last          = 1'b1;
    end else if (cmd.step && take && pend_v_r) begin
      out_load              = 1'b1;
      out_nxt.element       = pend_r;
      out_nxt.element_valid = 1'b1;
      out_nxt.found         = 1'b0;
      out_nxt.status        = ST_OK;
      out_nxt.last          = 1'b0;
    end else if (cmd.finish) begin
      out_load              = 1'b1;
      out_nxt.element       = pend_v_r ? pend_r : '0;
      out_nxt.element_valid = pend_v_r;
      out_nxt.found         = 1'b0;
      out_nxt.status        = ST_OK;
      out_nxt.last          = 1'b1;
    end
    out_v_nxt = out_load ? 1'b1 : (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (cmd.exec) begin
        if (op_r == OP_CLEAR) begin
          cnt_a_r <= '0;
          cnt_b_r <= '0;
        end else if (op_r == OP_INS_A && !hit_a && !full_a) begin
          cnt_a_r <= cnt_a_r + CNT_W'(1);
        end else if (op_r == OP_INS_B && !hit_b && !full_b) begin
          cnt_b_r <= cnt_b_r + CNT_W'(1);
        end
      end
      if (cmd.step && take) begin
        pend_v_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.opcode;
      val_r <= in_data.value;
    end
    if (cmd.exec && op_r == OP_INS_A && !hit_a && !full_a) begin
      a_r[cnt_a_r[AW-1:0]] <= val_r;
    end
    if (cmd.exec && op_r == OP_INS_B && !hit_b && !full_b) begin
      b_r[cnt_b_r[AW-1:0]] <= val_r;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.step && take) begin
      pend_r <= scan_item;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `ISE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_a_r <= CNT_W'(SET_DEPTH) && cnt_b_r <= CNT_W'(SET_DEPTH))
  `ISE_ASSERT_NXT(a_full_drop, clk, rst_n, cmd.exec && op_r == OP_INS_A && full_a, $stable(cnt_a_r))
  `ISE_ASSERT_NXT(a_fin_clears, clk, rst_n, cmd.finish, !pend_v_r && out_v_r && out_r.last)
  `ISE_ASSERT_IMP(a_elem_clean, clk, rst_n, out_v_r && out_r.element_valid, !out_r.found && out_r.status == ST_OK)

endmodule

// ===== sv/ise_ctrl.sv =====
// Controller: sequences capture, single-cycle commands and the set-operation scans.
module ise_ctrl import ise_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ise_sts_t sts,
  output ise_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN_A = 5'b00100,
    S_SCAN_B = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.set_op) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SCAN_A;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_A: begin
        cmd.mode_a = 1'b1;
        if (sts.a_end) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.is_union ? S_SCAN_B : S_FIN;
        end else if (!sts.stall) begin
          cmd.step = 1'b1;
        end
      end
      S_SCAN_B: begin
        cmd.mode_b = 1'b1;
        if (sts.b_end) begin
          state_nxt = S_FIN;
        end else if (!sts.stall) begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/integer_set_engine.sv =====
// Top level of the integer set engine: controller plus datapath.
// Holds two sets A and B of up to SET_DEPTH distinct signed 32-bit values in
// insertion order. One transaction is worked on at a time. Insert, query and
// clear are accepted, then executed (insert and query compare in parallel
// against every stored entry), and give one result. Intersect and difference
// scan A, union scans A and then B: the scan reads one stored entry per cycle
// unless stalled and matches it against the other set in parallel, and every
// emitted element is held back in a pending register so the final one can be
// flagged last. An empty result gives a single item with element_valid low.
// Results sit in an output register, so the next transaction is accepted while
// one waits; a scan pauses while the output register is full and not being taken.
module integer_set_engine import ise_pkg::*; #(
  parameter int SET_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  set_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output set_out_t out_data
);

  ise_cmd_t cmd;
  ise_sts_t sts;

  ise_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ise_dp #(
    .SET_DEPTH (SET_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
